// ===== rtl/crf_pkg.sv =====
// crf_pkg: shared types, codes and constants of the circle rasterizer.
// No dependencies; used by crf_if, the top module, crf_front, crf_back and the bench.
`timescale 1ns / 1ps
`default_nettype none

package crf_pkg;

  // fixed field widths
  localparam int COLOUR_BITS    = 8;
  localparam int CANVAS_BITS    = 11;
  localparam int CFG_INDEX_BITS = 2;

  localparam logic [CANVAS_BITS-1:0] CANVAS_RESET = 11'd320;

  // configuration register indexes
  localparam logic [CFG_INDEX_BITS-1:0] REG_CANVAS_COLS = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_CANVAS_ROWS = 2'd1;

  // command codes
  typedef enum logic {
    CMD_START = 1'b0,
    CMD_STEP  = 1'b1
  } cmd_t;

  // per-step flags carried with each queued step
  typedef struct packed {
    logic idle;   // step arrived with no circle in progress
    logic done;   // this step finishes the circle, or arrived idle
  } step_flags_t;

  localparam int FLAG_BITS = $bits(step_flags_t);

  // queued step: flags, colour, centre col, centre row, u, v
  function automatic int desc_bits(input int coord_bits);
    return FLAG_BITS + COLOUR_BITS + 4 * coord_bits;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/crf_if.sv =====
// crf_if: valid/ready channel interfaces of the circle rasterizer
// (command input, pixel write output, register write port); uses crf_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface crf_cmd_if #(parameter int COORD_BITS = 10) ();
  logic                               valid;
  logic                               ready;
  logic                               command;
  logic [COORD_BITS-1:0]              centre_x;
  logic [COORD_BITS-1:0]              centre_y;
  logic [COORD_BITS-1:0]              radius;
  logic [crf_pkg::COLOUR_BITS-1:0]    colour;
  logic                               fill_mode;

  modport source (output valid, command, centre_x, centre_y, radius, colour, fill_mode,
                  input ready);
  modport sink   (input valid, command, centre_x, centre_y, radius, colour, fill_mode,
                  output ready);
endinterface

interface crf_pix_if #(parameter int COORD_BITS = 10) ();
  logic                               valid;
  logic                               ready;
  logic [COORD_BITS-1:0]              pixel_row;
  logic [COORD_BITS-1:0]              pixel_col;
  logic [crf_pkg::COLOUR_BITS-1:0]    pixel_colour;
  logic                               write_enable;
  logic                               last_of_step;
  logic                               figure_done;

  modport source (output valid, pixel_row, pixel_col, pixel_colour, write_enable,
                  last_of_step, figure_done, input ready);
  modport sink   (input valid, pixel_row, pixel_col, pixel_colour, write_enable,
                  last_of_step, figure_done, output ready);
endinterface

interface crf_cfg_if ();
  logic                                 valid;
  logic                                 ready;
  logic [crf_pkg::CFG_INDEX_BITS-1:0]   index;
  logic [crf_pkg::CANVAS_BITS-1:0]      data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/circle_rasterizer_with_fill.sv =====
// circle_rasterizer_with_fill: midpoint circle generator with span fill.
// Depends on crf_pkg, crf_if, crf_front, crf_fifo and crf_back.
//
// Usage:
//   cmd  - command requests. A start request loads centre, radius, colour and
//          fill mode and produces no writes. A step request produces eight pixel
//          writes (one write if no circle is in progress, flagged done).
//   pix  - pixel write requests, one per cycle while pix.ready is high; the
//          last write of a step carries last_of_step, and of the final step
//          figure_done. Clipped writes have write_enable low and row/col zero.
//   cfg  - register writes (canvas_cols, canvas_rows), always ready; write only
//          while no step is outstanding.
// Flow: an accepted step enters the step queue, and its first write is then
//   loaded from the queue head into the output register; the back part then
//   sends one write per cycle while pix.ready is high, through the single
//   write port. A two-entry step queue lets commands keep arriving meanwhile.
// Stall: when pix.ready is low the output register holds; the queue fills and
//   cmd.ready drops once two steps wait.
// Reset: rst (synchronous) empties the queue, goes idle and sets both canvas
//   sizes to 320.
`timescale 1ns / 1ps
`default_nettype none

module circle_rasterizer_with_fill #(
  parameter int COORD_BITS = 10
) (
  input  logic       clk,
  input  logic       rst,
  crf_cmd_if.sink    cmd,
  crf_pix_if.source  pix,
  crf_cfg_if.sink    cfg
);
  import crf_pkg::*;

  localparam int DESC_BITS = desc_bits(COORD_BITS);

  logic [CANVAS_BITS-1:0] canvas_cols;
  logic [CANVAS_BITS-1:0] canvas_rows;

  logic                 q_push;
  logic [DESC_BITS-1:0] q_push_data;
  logic                 q_full;
  logic                 q_pop;
  logic                 q_valid;
  logic [DESC_BITS-1:0] q_data;

  // configuration registers
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      canvas_cols <= CANVAS_RESET;
      canvas_rows <= CANVAS_RESET;
    end else if (cfg.valid && cfg.ready) begin
      if (cfg.index == REG_CANVAS_COLS) canvas_cols <= cfg.data;
      if (cfg.index == REG_CANVAS_ROWS) canvas_rows <= cfg.data;
    end
  end

  crf_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full)
  );

  crf_fifo #(.WIDTH(DESC_BITS)) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_data  (q_push_data),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_data  (q_data)
  );

  crf_back #(.COORD_BITS(COORD_BITS)) u_back (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (q_valid),
    .head_data   (q_data),
    .pop         (q_pop),
    .canvas_cols (canvas_cols),
    .canvas_rows (canvas_rows),
    .pix         (pix)
  );

  // an accepted step is waiting in the queue on the next cycle
  a_step_queued: assert property (@(posedge clk) disable iff (rst)
    (cmd.valid && cmd.ready && cmd.command == CMD_STEP) |=> q_valid)
    else $error("accepted step request missing from queue");

  // done only ever marks the last write of a step
  a_done_on_last: assert property (@(posedge clk) disable iff (rst)
    (pix.valid && pix.figure_done) |-> pix.last_of_step)
    else $error("figure_done without last_of_step");

  // clipped writes carry a zero position
  a_clip_zero: assert property (@(posedge clk) disable iff (rst)
    (pix.valid && !pix.write_enable) |-> (pix.pixel_row == '0 && pix.pixel_col == '0))
    else $error("disabled write with nonzero position");

endmodule

`default_nettype wire

// ===== rtl/crf_fifo.sv =====
// crf_fifo: two-entry register queue between the front and back parts.
// Generic payload width; no package dependency.
`timescale 1ns / 1ps
`default_nettype none

module crf_fifo #(
  parameter int WIDTH = 52
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output logic [WIDTH-1:0] head_data
);

  localparam int DEPTH = 2;
  localparam int PTR_BITS = $clog2(DEPTH);
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]    entries [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [CNT_BITS-1:0] count;
  logic                do_push;
  logic                do_pop;

  assign full       = (count == CNT_BITS'(DEPTH));
  assign head_valid = (count != '0);
  assign head_data  = entries[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count + CNT_BITS'(do_push) - CNT_BITS'(do_pop);
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) entries[wr_ptr] <= push_data;
  end

endmodule

`default_nettype wire

// ===== rtl/crf_front.sv =====
// crf_front: takes command requests, holds the midpoint walk state and queues
// one step record per step request; uses crf_pkg and crf_cmd_if.
`timescale 1ns / 1ps
`default_nettype none

module crf_front #(
  parameter int COORD_BITS = 10
) (
  input  logic                                          clk,
  input  logic                                          rst,
  crf_cmd_if.sink                                       cmd,
  output logic                                          push,
  output logic [crf_pkg::desc_bits(COORD_BITS)-1:0]     push_data,
  input  logic                                          full
);
  import crf_pkg::*;

  localparam int C  = COORD_BITS;
  localparam int DW = COORD_BITS + 4;

  logic                   active;
  logic [C-1:0]           centre_col;
  logic [C-1:0]           centre_row;
  logic [C:0]             octant_x;
  logic [C-1:0]           octant_y;
  logic [C-1:0]           span_index;
  logic signed [DW-1:0]   decision;
  logic [COLOUR_BITS-1:0] draw_colour;
  logic                   fill_on;

  logic                   accept;
  logic                   is_step;
  logic                   span_more;
  logic [C:0]             x_inc;
  logic [C-1:0]           y_next;
  logic signed [C+1:0]    x_minus_y;
  logic signed [DW-1:0]   decision_next;
  logic                   done;
  logic [C-1:0]           v_sel;
  step_flags_t            flags;

  assign cmd.ready = !full;
  assign accept    = cmd.valid && cmd.ready;
  assign is_step   = (cmd.command == CMD_STEP);

  // decision update and end-of-circle test
  always_comb begin
    span_more = fill_on && (span_index < octant_y);
    x_inc     = octant_x + 1'b1;
    x_minus_y = $signed({1'b0, octant_x}) - $signed({2'b00, octant_y});
    if (decision < 0) begin
      decision_next = decision + $signed(DW'({octant_x, 2'b00})) + DW'(6);
      y_next        = octant_y;
    end else begin
      decision_next = decision + $signed({x_minus_y, 2'b00}) + DW'(10);
      y_next        = octant_y - 1'b1;
    end
    // y stepping below zero (radius zero) also ends the circle
    done = !span_more &&
           ((x_inc > {1'b0, y_next}) || (!decision[DW-1] && (octant_y == '0)));
  end

  // step record for the back part
  always_comb begin
    v_sel      = fill_on ? span_index : octant_y;
    flags.idle = !active;
    flags.done = !active || done;
    if (active) begin
      push_data = {flags, draw_colour, centre_col, centre_row, octant_x[C-1:0], v_sel};
    end else begin
      push_data = {flags, {(COLOUR_BITS + 4 * C){1'b0}}};
    end
    push = accept && is_step;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (accept) begin
      if (!is_step) begin
        active <= 1'b1;
      end else if (active && done) begin
        active <= 1'b0;
      end
    end
  end

  // walk state
  always_ff @(posedge clk) begin
    if (rst) begin
      centre_col  <= '0;
      centre_row  <= '0;
      octant_x    <= '0;
      octant_y    <= '0;
      span_index  <= '0;
      decision    <= '0;
      draw_colour <= '0;
      fill_on     <= 1'b0;
    end else if (accept) begin
      if (!is_step) begin
        centre_col  <= cmd.centre_x;
        centre_row  <= cmd.centre_y;
        draw_colour <= cmd.colour;
        fill_on     <= cmd.fill_mode;
        octant_x    <= '0;
        octant_y    <= cmd.radius;
        span_index  <= '0;
        decision    <= DW'(3) - $signed(DW'({cmd.radius, 1'b0}));
      end else if (active) begin
        if (span_more) begin
          span_index <= span_index + 1'b1;
        end else begin
          decision   <= decision_next;
          octant_y   <= y_next;
          octant_x   <= x_inc;
          span_index <= x_inc[C-1:0];
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/crf_back.sv =====
// crf_back: expands each queued step into its eight symmetric pixel writes (one for an
// idle step), clips them to the canvas and drives the output register; uses crf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module crf_back #(
  parameter int COORD_BITS = 10
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          head_valid,
  input  logic [crf_pkg::desc_bits(COORD_BITS)-1:0]     head_data,
  output logic                                          pop,
  input  logic [crf_pkg::CANVAS_BITS-1:0]               canvas_cols,
  input  logic [crf_pkg::CANVAS_BITS-1:0]               canvas_rows,
  crf_pix_if.source                                     pix
);
  import crf_pkg::*;

  localparam int C    = COORD_BITS;
  localparam int SW   = COORD_BITS + 2;
  localparam int CMPW = (COORD_BITS > CANVAS_BITS) ? COORD_BITS : CANVAS_BITS;

  step_flags_t            flags;
  logic [COLOUR_BITS-1:0] colour;
  logic [C-1:0]           cx;
  logic [C-1:0]           cy;
  logic [C-1:0]           u;
  logic [C-1:0]           v;

  logic [2:0]             k;
  logic                   load;
  logic                   last;
  logic [C-1:0]           row_off;
  logic [C-1:0]           col_off;
  logic signed [SW-1:0]   row;
  logic signed [SW-1:0]   col;
  logic                   row_ok;
  logic                   col_ok;
  logic                   en;

  logic                   out_valid;
  logic [C-1:0]           out_row;
  logic [C-1:0]           out_col;
  logic [COLOUR_BITS-1:0] out_colour;
  logic                   out_en;
  logic                   out_last;
  logic                   out_done;

  assign {flags, colour, cx, cy, u, v} = head_data;

  // write k of the step: bit 2 swaps u and v, bit 1 negates row, bit 0 column
  always_comb begin
    row_off = k[2] ? u : v;
    col_off = k[2] ? v : u;
    row = k[1] ? ($signed({2'b00, cy}) - $signed({2'b00, row_off}))
               : ($signed({2'b00, cy}) + $signed({2'b00, row_off}));
    col = k[0] ? ($signed({2'b00, cx}) - $signed({2'b00, col_off}))
               : ($signed({2'b00, cx}) + $signed({2'b00, col_off}));
    row_ok = (row[SW-1:C] == '0) && (CMPW'(row[C-1:0]) < CMPW'(canvas_rows));
    col_ok = (col[SW-1:C] == '0) && (CMPW'(col[C-1:0]) < CMPW'(canvas_cols));
    en     = row_ok && col_ok && !flags.idle;
  end

  assign load = head_valid && (!out_valid || pix.ready);
  assign last = flags.idle || (k == 3'd7);
  assign pop  = load && last;

  // write counter and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      k         <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        k         <= last ? 3'd0 : k + 3'd1;
        out_valid <= 1'b1;
      end else if (pix.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (load) begin
      out_row    <= en ? row[C-1:0] : '0;
      out_col    <= en ? col[C-1:0] : '0;
      out_colour <= colour;
      out_en     <= en;
      out_last   <= last;
      out_done   <= last && flags.done;
    end
  end

  assign pix.valid        = out_valid;
  assign pix.pixel_row    = out_row;
  assign pix.pixel_col    = out_col;
  assign pix.pixel_colour = out_colour;
  assign pix.write_enable = out_en;
  assign pix.last_of_step = out_last;
  assign pix.figure_done  = out_done;

endmodule

`default_nettype wire

// ===== bench/circle_rasterizer_with_fill_test.sv =====
// circle_rasterizer_with_fill_test: self-checking bench for the circle rasterizer.
// Depends on crf_pkg, crf_if and circle_rasterizer_with_fill; a scoreboard class
// predicts every pixel write and checks the output stream in order.
`timescale 1ns / 1ps

module circle_rasterizer_with_fill_test;
  import crf_pkg::*;

  localparam int COORD_BITS   = 10;
  localparam int COORD_LIMIT  = 1 << COORD_BITS;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 16;
  localparam int MAX_REPORTS  = 10;
  localparam int HOLD_CYCLES  = 150;

  // indexes past the register list, writes there are ignored
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_3 = 2'd3;

  typedef struct packed {
    logic [COORD_BITS-1:0]  row;
    logic [COORD_BITS-1:0]  col;
    logic [COLOUR_BITS-1:0] colour;
    logic                   en;
    logic                   last;
    logic                   done;
  } pixel_write_t;

  typedef struct packed {
    cmd_t                   command;
    logic [COORD_BITS-1:0]  cx;
    logic [COORD_BITS-1:0]  cy;
    logic [COORD_BITS-1:0]  radius;
    logic [COLOUR_BITS-1:0] colour;
    logic                   fill;
  } circle_cmd_t;

  // midpoint circle predictor plus in-order write checker
  class pixel_scoreboard;
    logic [CANVAS_BITS-1:0] canvas_cols;
    logic [CANVAS_BITS-1:0] canvas_rows;
    bit                     circle_open;
    logic [COORD_BITS-1:0]  centre_col;
    logic [COORD_BITS-1:0]  centre_row;
    int                     octant_x;
    int                     octant_y;
    int                     span_index;
    int                     decision;
    logic [COLOUR_BITS-1:0] draw_colour;
    bit                     fill_on;
    pixel_write_t           expected_writes[$];
    int                     errors;

    function new();
      canvas_cols = CANVAS_RESET;
      canvas_rows = CANVAS_RESET;
      circle_open = 1'b0;
      centre_col  = '0;
      centre_row  = '0;
      octant_x    = 0;
      octant_y    = 0;
      span_index  = 0;
      decision    = 0;
      draw_colour = '0;
      fill_on     = 1'b0;
      errors      = 0;
    endfunction

    function void write_register(logic [CFG_INDEX_BITS-1:0] idx,
                                 logic [CANVAS_BITS-1:0] val);
      if (idx == REG_CANVAS_COLS) canvas_cols = val;
      else if (idx == REG_CANVAS_ROWS) canvas_rows = val;
    endfunction

    function pixel_write_t clipped(int row, int col, bit last_flag);
      pixel_write_t w;
      bit en;
      en = row >= 0 && col >= 0 && row < int'(canvas_rows) && col < int'(canvas_cols) &&
           row < COORD_LIMIT && col < COORD_LIMIT;
      w.row    = en ? COORD_BITS'(row) : '0;
      w.col    = en ? COORD_BITS'(col) : '0;
      w.colour = draw_colour;
      w.en     = en;
      w.last   = last_flag;
      w.done   = 1'b0;
      return w;
    endfunction

    // called once per accepted command request
    function void note_request(circle_cmd_t req);
      pixel_write_t batch[8];
      pixel_write_t w;
      int cx, cy, u, v;
      if (req.command == CMD_START) begin
        centre_col  = req.cx;
        centre_row  = req.cy;
        draw_colour = req.colour;
        fill_on     = req.fill;
        octant_x    = 0;
        octant_y    = int'(req.radius);
        span_index  = 0;
        decision    = 3 - 2 * int'(req.radius);
        circle_open = 1'b1;
        return;
      end
      // step with no circle in progress
      if (!circle_open) begin
        w      = '0;
        w.last = 1'b1;
        w.done = 1'b1;
        expected_writes.push_back(w);
        return;
      end
      cx = int'(centre_col);
      cy = int'(centre_row);
      u  = octant_x;
      v  = fill_on ? span_index : octant_y;
      batch[0] = clipped(cy + v, cx + u, 1'b0);
      batch[1] = clipped(cy + v, cx - u, 1'b0);
      batch[2] = clipped(cy - v, cx + u, 1'b0);
      batch[3] = clipped(cy - v, cx - u, 1'b0);
      batch[4] = clipped(cy + u, cx + v, 1'b0);
      batch[5] = clipped(cy + u, cx - v, 1'b0);
      batch[6] = clipped(cy - u, cx + v, 1'b0);
      batch[7] = clipped(cy - u, cx - v, 1'b1);
      // fill walks the span before the octant advances
      if (fill_on && span_index < octant_y) begin
        span_index++;
      end else begin
        if (decision < 0) begin
          decision = decision + 4 * octant_x + 6;
        end else begin
          decision = decision + 4 * (octant_x - octant_y) + 10;
          octant_y--;
        end
        octant_x++;
        span_index = octant_x;
        if (octant_x > octant_y) begin
          circle_open   = 1'b0;
          batch[7].done = 1'b1;
        end
      end
      foreach (batch[i]) expected_writes.push_back(batch[i]);
    endfunction

    // called once per accepted pixel write
    function void check_write(pixel_write_t got);
      pixel_write_t want;
      if (expected_writes.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: unexpected write row %0d col %0d colour %0h en %0b last %0b done %0b",
                   $realtime, got.row, got.col, got.colour, got.en, got.last, got.done);
        return;
      end
      want = expected_writes.pop_front();
      if (got.row !== want.row || got.col !== want.col || got.colour !== want.colour ||
          got.en !== want.en || got.last !== want.last || got.done !== want.done) begin
        errors++;
        if (errors <= MAX_REPORTS) begin
          $display("%0t: write mismatch", $realtime);
          $display("  expected row %0d col %0d colour %0h en %0b last %0b done %0b",
                   want.row, want.col, want.colour, want.en, want.last, want.done);
          $display("  actual   row %0d col %0d colour %0h en %0b last %0b done %0b",
                   got.row, got.col, got.colour, got.en, got.last, got.done);
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst;

  crf_cmd_if #(.COORD_BITS(COORD_BITS)) cmd_ch ();
  crf_pix_if #(.COORD_BITS(COORD_BITS)) pix_ch ();
  crf_cfg_if                            cfg_ch ();

  circle_rasterizer_with_fill #(.COORD_BITS(COORD_BITS)) uut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .pix (pix_ch),
    .cfg (cfg_ch)
  );

  pixel_scoreboard sb = new();

  bit cmd_idling;
  bit pix_idling;
  int hold_request;
  int requests_sent;
  int cycle_count;

  // 4 ns clock
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d writes outstanding",
               cycle_count, sb.expected_writes.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // output monitor
  always @(posedge clk) begin : pixel_monitor
    pixel_write_t seen;
    seen.row    = pix_ch.pixel_row;
    seen.col    = pix_ch.pixel_col;
    seen.colour = pix_ch.pixel_colour;
    seen.en     = pix_ch.write_enable;
    seen.last   = pix_ch.last_of_step;
    seen.done   = pix_ch.figure_done;
    if (rst === 1'b0 && pix_ch.valid === 1'b1 && pix_ch.ready === 1'b1)
      sb.check_write(seen);
  end

  // pixel write receiver: random stalls and requested long hold-offs
  initial begin : pixel_receiver
    int stall;
    pix_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if (hold_request > 0) begin
        pix_ch.ready <= 1'b0;
        repeat (hold_request) @(posedge clk);
        hold_request = 0;
      end
      stall = pix_idling ? $urandom_range(0, 5) : 0;
      if (stall > 0) begin
        pix_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      pix_ch.ready <= 1'b1;
      do @(posedge clk); while (pix_ch.valid !== 1'b1);
    end
  end

  // drive one command request and note it once accepted
  task automatic send_request(circle_cmd_t req);
    int gap;
    gap = cmd_idling ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_ch.valid     <= 1'b1;
    cmd_ch.command   <= req.command;
    cmd_ch.centre_x  <= req.cx;
    cmd_ch.centre_y  <= req.cy;
    cmd_ch.radius    <= req.radius;
    cmd_ch.colour    <= req.colour;
    cmd_ch.fill_mode <= req.fill;
    do @(posedge clk); while (cmd_ch.ready !== 1'b1);
    sb.note_request(req);
    requests_sent++;
  endtask

  // stop sending and wait for every write plus the tail latency
  task automatic drain_writes();
    cmd_ch.valid <= 1'b0;
    while (sb.expected_writes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(logic [CFG_INDEX_BITS-1:0] idx,
                                logic [CANVAS_BITS-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    sb.write_register(idx, val);
  endtask

  task automatic set_canvas(logic [CANVAS_BITS-1:0] cols, logic [CANVAS_BITS-1:0] rows);
    write_register(REG_CANVAS_COLS, cols);
    write_register(REG_CANVAS_ROWS, rows);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic circle_cmd_t start_cmd(int cx, int cy, int radius, int colour, bit fill);
    circle_cmd_t c;
    c.command = CMD_START;
    c.cx      = COORD_BITS'(cx);
    c.cy      = COORD_BITS'(cy);
    c.radius  = COORD_BITS'(radius);
    c.colour  = COLOUR_BITS'(colour);
    c.fill    = fill;
    return c;
  endfunction

  // step requests carry random payload, which the block ignores
  function automatic circle_cmd_t step_cmd();
    circle_cmd_t c;
    c = start_cmd($urandom, $urandom, $urandom, $urandom, 1'($urandom_range(0, 1)));
    c.command = CMD_STEP;
    return c;
  endfunction

  // centre coordinate near zero, near the canvas edge, or anywhere
  function automatic int pick_centre(logic [CANVAS_BITS-1:0] size);
    int t;
    case ($urandom_range(0, 3))
      0: t = $urandom_range(0, 4);
      1: t = int'(size) - int'($urandom_range(0, 4));
      default: t = $urandom_range(0, COORD_LIMIT - 1);
    endcase
    if (t < 0) t = 0;
    if (t > COORD_LIMIT - 1) t = COORD_LIMIT - 1;
    return t;
  endfunction

  function automatic circle_cmd_t random_start();
    int radius;
    case ($urandom_range(0, 9))
      0: radius = $urandom_range(0, COORD_LIMIT - 1);
      1, 2: radius = $urandom_range(11, 40);
      default: radius = $urandom_range(0, 10);
    endcase
    return start_cmd(pick_centre(sb.canvas_cols), pick_centre(sb.canvas_rows), radius,
                     $urandom_range(0, 255), 1'($urandom_range(0, 1)));
  endfunction

  // start a circle and step it until it ends or the step budget runs out
  task automatic trace_circle(circle_cmd_t start, int max_steps);
    int steps;
    steps = 0;
    send_request(start);
    while (sb.circle_open && steps < max_steps) begin
      send_request(step_cmd());
      steps++;
    end
  endtask

  task automatic random_circles(int count);
    int target;
    target = requests_sent + count;
    while (requests_sent < target) begin
      cmd_idling = $urandom_range(0, 9) < 6;
      pix_idling = $urandom_range(0, 9) < 6;
      if ($urandom_range(0, 9) == 0) begin
        // stray step, mid-circle or idle
        send_request(step_cmd());
      end else begin
        trace_circle(random_start(),
                     ($urandom_range(0, 9) == 0) ? $urandom_range(1, 4) : 24);
        if ($urandom_range(0, 6) == 0) send_request(step_cmd());
      end
    end
  endtask

  initial begin : stimulus
    rst              <= 1'b1;
    cmd_ch.valid     <= 1'b0;
    cmd_ch.command   <= CMD_START;
    cmd_ch.centre_x  <= '0;
    cmd_ch.centre_y  <= '0;
    cmd_ch.radius    <= '0;
    cmd_ch.colour    <= '0;
    cmd_ch.fill_mode <= 1'b0;
    cfg_ch.valid     <= 1'b0;
    cfg_ch.index     <= REG_CANVAS_COLS;
    cfg_ch.data      <= '0;
    cmd_idling       = 1'b0;
    pix_idling       = 1'b0;
    hold_request     = 0;
    requests_sent    = 0;
    cycle_count      = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed cases on the default 320x320 canvas
    send_request(step_cmd());
    trace_circle(start_cmd(0, 0, 0, 0, 1'b0), 4);
    send_request(step_cmd());
    trace_circle(start_cmd(1023, 1023, 0, 255, 1'b1), 4);
    // largest radius, cut short and restarted mid-circle
    trace_circle(start_cmd(512, 512, 1023, 'haa, 1'b0), 2);
    trace_circle(start_cmd(1023, 0, 1023, 'h55, 1'b1), 2);
    cmd_idling = 1'b1;
    pix_idling = 1'b1;
    trace_circle(start_cmd(319, 319, 2, 'h0f, 1'b1), 10);
    trace_circle(start_cmd(2, 317, 3, 'hf0, 1'b0), 10);
    send_request(step_cmd());
    drain_writes();

    // random phases, each with its own canvas setting
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: set_canvas(11'd1024, 11'd1);
        1: set_canvas(11'd1, 11'd1024);
        2: begin
          write_register(REG_SPARE_2, CANVAS_BITS'($urandom));
          write_register(REG_SPARE_3, CANVAS_BITS'($urandom));
          set_canvas(11'd0, 11'd2047);
        end
        3: set_canvas(CANVAS_BITS'($urandom_range(8, 64)),
                      CANVAS_BITS'($urandom_range(8, 64)));
        default: set_canvas(11'd2047, CANVAS_BITS'($urandom_range(1, 1024)));
      endcase
      // output held off while requests keep coming
      if (phase == 1 || phase == 3) begin
        cmd_idling   = 1'b0;
        hold_request = HOLD_CYCLES;
        trace_circle(random_start(), 8);
      end
      random_circles(10);
      drain_writes();
    end

    if (sb.errors == 0 && sb.expected_writes.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      if (sb.expected_writes.size() != 0)
        $display("%0d expected writes never arrived", sb.expected_writes.size());
      $display("%0d mismatches", sb.errors);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
